### sv/ffa_pkg.sv
`timescale 1ns / 1ps

package ffa_pkg;

    // default descriptor pool depth
    localparam int DEF_MAX_BLOCKS = 64;

    // field widths
    localparam int AW     = 32;          // addresses
    localparam int SW     = 25;          // block sizes
    localparam int RW     = 24;          // request bytes
    localparam int TW     = 24;          // split threshold
    localparam int LW     = 4;           // align_log2
    localparam int CNTW   = 7;           // reported counts
    localparam int PADW   = AW + 1 - SW; // size to 33-bit sum padding
    localparam int IN_DW  = 56;          // slave tdata width
    localparam int OUT_DW = 56;          // master tdata width
    localparam int CFG_IW = 2;           // register index width
    localparam int CFG_DW = 32;          // register data width

    // largest size a merged run may reach
    localparam logic [AW:0] SIZE_CAP = 33'h1FF_FFFF;

    // alignment above this acts as this
    localparam logic [LW-1:0] ALIGN_MAX = 4'd8;

    // request kinds
    localparam logic [1:0] KIND_ALLOC = 2'd0;
    localparam logic [1:0] KIND_FREE  = 2'd1;
    localparam logic [1:0] KIND_INIT  = 2'd2;
    localparam logic [1:0] KIND_SPARE = 2'd3;   // unused, reported as ignored

    // result status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_NO_SPACE = 2'd1;
    localparam logic [1:0] STAT_NOT_USED = 2'd2;
    localparam logic [1:0] STAT_IGNORED  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IW-1:0] CFG_HEAP_START = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_HEAP_LIMIT = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_SPLIT_THR  = 2'd2;
    localparam logic [CFG_IW-1:0] CFG_ALIGN_LOG2 = 2'd3;

    // what the descriptor scan is looking for
    typedef enum logic [2:0] {
        MODE_ALLOC = 3'b001,
        MODE_FREE  = 3'b010,
        MODE_MERGE = 3'b100
    } t_mode;

    // scan control from the sequencer
    typedef struct packed {
        logic          clr;
        t_mode         mode;
        logic          have_key;
        logic [AW-1:0] key_addr;
        logic [SW-1:0] num;
        logic [AW-1:0] top;
        logic [AW-1:0] lim;
        logic [AW-1:0] rel;
    } t_scan_ctl;

    // one descriptor as read back from the tables
    typedef struct packed {
        logic          vld;
        logic          is_free;
        logic          is_used;
        logic [AW-1:0] addr;
        logic [SW-1:0] size;
    } t_scan_ent;

    // running result of a scan
    typedef struct packed {
        logic          found;
        logic          at_top;
        logic [AW-1:0] addr;
        logic [SW-1:0] size;
        logic          fresh_found;
    } t_scan_res;

endpackage

### sv/ffa_scan.sv
`timescale 1ns / 1ps

// Shared compare unit: one descriptor a cycle, keeps the lowest-keyed
// eligible entry and the first blank descriptor seen.
module ffa_scan import ffa_pkg::*; #(
    parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
    localparam int IW = $clog2(MAX_BLOCKS)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_scan_ctl       i_ctl,
    input  logic [IW-1:0]   i_key_idx,
    input  t_scan_ent       i_ent,
    input  logic [IW-1:0]   i_ent_idx,
    output t_scan_res       o_res,
    output logic [IW-1:0]   o_best_idx,
    output logic [IW-1:0]   o_fresh_idx
);

    logic          r_found;
    logic          r_fresh_found;
    logic          r_at_top;
    logic [AW-1:0] r_addr;
    logic [SW-1:0] r_size;
    logic [IW-1:0] r_idx;
    logic [IW-1:0] r_fidx;

    logic [AW:0]   w_end;
    logic [AW:0]   w_reach;
    logic          w_at_top;
    logic          w_key_gt;
    logic          w_elig;
    logic          w_better;
    logic          w_fresh;

    // end of this block and end if resized to the request
    assign w_end    = {1'b0, i_ent.addr} + {{PADW{1'b0}}, i_ent.size};
    assign w_reach  = {1'b0, i_ent.addr} + {{PADW{1'b0}}, i_ctl.num};
    assign w_at_top = (w_end >= {1'b0, i_ctl.top}) && (w_reach <= {1'b0, i_ctl.lim});

    // strictly after the last key in (address, index) order
    assign w_key_gt = !i_ctl.have_key || (i_ent.addr > i_ctl.key_addr) ||
                      ((i_ent.addr == i_ctl.key_addr) && (i_ent_idx > i_key_idx));

    always_comb begin
        unique case (i_ctl.mode)
            MODE_ALLOC: w_elig = i_ent.is_free && (w_at_top || (i_ent.size >= i_ctl.num));
            MODE_FREE:  w_elig = i_ent.is_used && (i_ent.addr == i_ctl.rel);
            MODE_MERGE: w_elig = i_ent.is_free && w_key_gt;
            default:    w_elig = 1'b0;
        endcase
    end

    // index ascends, so a strict compare keeps the lowest index on ties
    assign w_better = i_ent.vld && w_elig && (!r_found || (i_ent.addr < r_addr));
    assign w_fresh  = i_ent.vld && !i_ent.is_free && !i_ent.is_used && !r_fresh_found;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found       <= 1'b0;
            r_fresh_found <= 1'b0;
        end else if (i_ctl.clr) begin
            r_found       <= 1'b0;
            r_fresh_found <= 1'b0;
        end else begin
            if (w_better) r_found <= 1'b1;
            if (w_fresh)  r_fresh_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_better) begin
            r_addr   <= i_ent.addr;
            r_size   <= i_ent.size;
            r_at_top <= w_at_top;
            r_idx    <= i_ent_idx;
        end
        if (w_fresh) r_fidx <= i_ent_idx;
    end

    assign o_res.found       = r_found;
    assign o_res.at_top      = r_at_top;
    assign o_res.addr        = r_addr;
    assign o_res.size        = r_size;
    assign o_res.fresh_found = r_fresh_found;
    assign o_best_idx        = r_idx;
    assign o_fresh_idx       = r_fidx;

endmodule

### sv/first_fit_block_allocator.sv
`timescale 1ns / 1ps

// First-fit block allocator over a pool of MAX_BLOCKS descriptors.
// Slave stream takes requests: tuser is the kind (allocate, free, init),
// tdata the request size and the address to release. Master stream gives
// one beat per request: granted address, status and the three descriptor
// counts. The config channel writes heap_start, heap_limit, split_threshold
// and align_log2, and is always ready; write it only while idle.
// Init, zero-byte allocates, frees of address zero and the unused kind skip
// the scan and go straight to the result step.
// Every other request passes one scan of the descriptor tables, one entry a
// cycle through a single compare unit, and then loads its result. A free
// that finds its block, or an allocate that splits a block, then merges
// neighbours: each merge step is another scan, and a split first writes the
// size of the split-off block. One request is in work at a time; tready is
// high only between requests.
// Reset marks all descriptors blank and the top pointer zero at once; no
// clearing pass is needed. A stalled result sits in the output register and
// the next request is still accepted; its own result waits until the
// register empties.
module first_fit_block_allocator import ffa_pkg::*; #(
    parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [IN_DW-1:0]  i_s_tdata,    // request_bytes[23:0], release_address[55:24]
    input  logic [1:0]        i_s_tuser,    // kind[1:0]
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [OUT_DW-1:0] o_m_tdata,    // granted_address[31:0], status[33:32],
                                            // free_count[40:34], used_count[47:41],
                                            // fresh_count[54:48], zero[55]
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [CFG_DW-1:0] i_cfg_data
);

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_SPLIT = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    // configuration
    logic [AW-1:0] r_heap_start;
    logic [AW-1:0] r_heap_limit;
    logic [TW-1:0] r_split_thr;
    logic [LW-1:0] r_align;

    // descriptor tables
    logic [AW-1:0]   r_addr_mem [MAX_BLOCKS];
    logic [SW-1:0]   r_size_mem [MAX_BLOCKS];
    logic [AW-1:0]   r_mem_a;
    logic [SW-1:0]   r_mem_z;
    logic [MAX_BLOCKS-1:0] r_free_v, n_free_v;
    logic [MAX_BLOCKS-1:0] r_used_v, n_used_v;

    // sequencer
    t_state        r_state, n_state;
    t_mode         r_mode, n_mode;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_pv, n_pv;
    logic [IW-1:0] r_pidx, n_pidx;
    logic [SW-1:0] r_num, n_num;
    logic [AW-1:0] r_rel, n_rel;
    logic [AW-1:0] r_top, n_top;
    logic [CW-1:0] r_free_cnt, n_free_cnt;
    logic [CW-1:0] r_used_cnt, n_used_cnt;
    logic [CW-1:0] r_fresh_cnt, n_fresh_cnt;
    logic [AW-1:0] r_grant, n_grant;
    logic [1:0]    r_status, n_status;

    // merge run
    logic          r_have_key, n_have_key;
    logic [AW-1:0] r_key_a, n_key_a;
    logic [IW-1:0] r_key_i, n_key_i;
    logic [IW-1:0] r_run_s, n_run_s;
    logic [AW-1:0] r_run_start, n_run_start;
    logic [AW:0]   r_run_end, n_run_end;

    // output register
    logic              r_out_vld, n_out_vld;
    logic [OUT_DW-1:0] r_out_data, n_out_data;

    // table write ports
    logic          w_a_we, w_z_we;
    logic [IW-1:0] w_a_wi, w_z_wi;
    logic [AW-1:0] w_a_wd;
    logic [SW-1:0] w_z_wd;

    // scan unit
    t_scan_ctl     w_ctl;
    t_scan_ent     w_ent;
    t_scan_res     w_res;
    logic [IW-1:0] w_bidx;
    logic [IW-1:0] w_fidx;

    // request decode and arithmetic
    logic [1:0]    w_kind;
    logic [RW-1:0] w_req;
    logic [AW-1:0] w_rel_in;
    logic [LW-1:0] w_align;
    logic [SW-1:0] w_mask;
    logic [SW-1:0] w_num;
    logic          w_scan_done;
    logic [AW:0]   w_best_reach;
    logic [AW:0]   w_top_reach;
    logic [SW-1:0] w_excess;
    logic [AW:0]   w_q_end;
    logic [AW:0]   w_q_len;
    logic [AW:0]   w_run_len;
    logic          w_absorb;

    assign w_req    = i_s_tdata[RW-1:0];
    assign w_rel_in = i_s_tdata[RW+AW-1:RW];
    assign w_kind   = i_s_tuser;

    // round the request up to the alignment
    assign w_align = (r_align > ALIGN_MAX) ? ALIGN_MAX : r_align;
    assign w_mask  = SW'((9'd1 << w_align) - 9'd1);
    assign w_num   = (SW'(w_req) + w_mask) & ~w_mask;

    assign w_scan_done  = (r_cnt == CW'(MAX_BLOCKS)) && !r_pv;
    assign w_best_reach = {1'b0, w_res.addr} + {{PADW{1'b0}}, r_num};
    assign w_top_reach  = {1'b0, r_top} + {{PADW{1'b0}}, r_num};
    assign w_excess     = w_res.size - r_num;
    assign w_q_end      = {1'b0, w_res.addr} + {{PADW{1'b0}}, w_res.size};
    assign w_q_len      = w_q_end - {1'b0, r_run_start};
    assign w_run_len    = r_run_end - {1'b0, r_run_start};
    assign w_absorb     = r_have_key && ({1'b0, w_res.addr} == r_run_end) &&
                          (w_q_len <= SIZE_CAP);

    // scan unit hookup
    assign w_ctl.clr      = (r_state == S_SCAN) && (r_cnt == '0);
    assign w_ctl.mode     = r_mode;
    assign w_ctl.have_key = r_have_key;
    assign w_ctl.key_addr = r_key_a;
    assign w_ctl.num      = r_num;
    assign w_ctl.top      = r_top;
    assign w_ctl.lim      = r_heap_limit;
    assign w_ctl.rel      = r_rel;

    assign w_ent.vld     = r_pv;
    assign w_ent.is_free = r_free_v[r_pidx];
    assign w_ent.is_used = r_used_v[r_pidx];
    assign w_ent.addr    = r_mem_a;
    assign w_ent.size    = r_mem_z;

    ffa_scan #(
        .MAX_BLOCKS(MAX_BLOCKS)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_key_idx  (r_key_i),
        .i_ent      (w_ent),
        .i_ent_idx  (r_pidx),
        .o_res      (w_res),
        .o_best_idx (w_bidx),
        .o_fresh_idx(w_fidx)
    );

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_cnt       = r_cnt;
        n_pv        = (r_state == S_SCAN) && (r_cnt < CW'(MAX_BLOCKS));
        n_pidx      = r_cnt[IW-1:0];
        n_num       = r_num;
        n_rel       = r_rel;
        n_top       = r_top;
        n_free_v    = r_free_v;
        n_used_v    = r_used_v;
        n_free_cnt  = r_free_cnt;
        n_used_cnt  = r_used_cnt;
        n_fresh_cnt = r_fresh_cnt;
        n_grant     = r_grant;
        n_status    = r_status;
        n_have_key  = r_have_key;
        n_key_a     = r_key_a;
        n_key_i     = r_key_i;
        n_run_s     = r_run_s;
        n_run_start = r_run_start;
        n_run_end   = r_run_end;
        n_out_vld   = r_out_vld && !i_m_tready;
        n_out_data  = r_out_data;
        w_a_we      = 1'b0;
        w_a_wi      = w_fidx;
        w_a_wd      = '0;
        w_z_we      = 1'b0;
        w_z_wi      = w_bidx;
        w_z_wd      = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_num      = w_num;
                    n_rel      = w_rel_in;
                    n_grant    = '0;
                    n_cnt      = '0;
                    n_have_key = 1'b0;
                    n_state    = S_DONE;
                    unique case (w_kind)
                        KIND_ALLOC: begin
                            if (w_req == '0) begin
                                n_status = STAT_NO_SPACE;
                            end else begin
                                n_mode  = MODE_ALLOC;
                                n_state = S_SCAN;
                            end
                        end
                        KIND_FREE: begin
                            if (w_rel_in == '0) begin
                                n_status = STAT_IGNORED;
                            end else begin
                                n_mode  = MODE_FREE;
                                n_state = S_SCAN;
                            end
                        end
                        KIND_INIT: begin
                            n_free_v    = '0;
                            n_used_v    = '0;
                            n_free_cnt  = '0;
                            n_used_cnt  = '0;
                            n_fresh_cnt = CW'(MAX_BLOCKS);
                            n_top       = r_heap_start;
                            n_status    = STAT_OK;
                        end
                        default: begin
                            n_status = STAT_IGNORED;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                if (r_cnt < CW'(MAX_BLOCKS)) n_cnt = r_cnt + CW'(1);
                if (w_scan_done) begin
                    unique case (r_mode)
                        MODE_ALLOC: begin
                            n_state = S_DONE;
                            if (w_res.found) begin
                                // reuse the first free block that fits
                                n_free_v[w_bidx] = 1'b0;
                                n_used_v[w_bidx] = 1'b1;
                                n_free_cnt = r_free_cnt - CW'(1);
                                n_used_cnt = r_used_cnt + CW'(1);
                                n_grant    = w_res.addr;
                                n_status   = STAT_OK;
                                if (w_res.at_top) begin
                                    w_z_we = 1'b1;
                                    w_z_wd = r_num;
                                    n_top  = w_best_reach[AW-1:0];
                                end else if (w_res.fresh_found &&
                                             (w_excess >= {1'b0, r_split_thr})) begin
                                    // split off the surplus as a new free block
                                    w_z_we = 1'b1;
                                    w_z_wd = r_num;
                                    w_a_we = 1'b1;
                                    w_a_wd = w_best_reach[AW-1:0];
                                    n_free_v[w_fidx] = 1'b1;
                                    n_free_cnt  = r_free_cnt;
                                    n_fresh_cnt = r_fresh_cnt - CW'(1);
                                    n_state     = S_SPLIT;
                                end
                            end else if (w_res.fresh_found &&
                                         (w_top_reach <= {1'b0, r_heap_limit})) begin
                                // carve new space at the top
                                w_a_we = 1'b1;
                                w_a_wd = r_top;
                                w_z_we = 1'b1;
                                w_z_wi = w_fidx;
                                w_z_wd = r_num;
                                n_used_v[w_fidx] = 1'b1;
                                n_used_cnt  = r_used_cnt + CW'(1);
                                n_fresh_cnt = r_fresh_cnt - CW'(1);
                                n_top    = w_top_reach[AW-1:0];
                                n_grant  = r_top;
                                n_status = STAT_OK;
                            end else begin
                                n_status = STAT_NO_SPACE;
                            end
                        end
                        MODE_FREE: begin
                            if (w_res.found) begin
                                n_free_v[w_bidx] = 1'b1;
                                n_used_v[w_bidx] = 1'b0;
                                n_free_cnt = r_free_cnt + CW'(1);
                                n_used_cnt = r_used_cnt - CW'(1);
                                n_status   = STAT_OK;
                                n_mode     = MODE_MERGE;
                                n_have_key = 1'b0;
                                n_cnt      = '0;
                            end else begin
                                n_status = STAT_NOT_USED;
                                n_state  = S_DONE;
                            end
                        end
                        MODE_MERGE: begin
                            if (!w_res.found) begin
                                // close the last run
                                if (r_have_key) begin
                                    w_z_we = 1'b1;
                                    w_z_wi = r_run_s;
                                    w_z_wd = w_run_len[SW-1:0];
                                end
                                n_state = S_DONE;
                            end else begin
                                if (w_absorb) begin
                                    n_free_v[w_bidx] = 1'b0;
                                    n_free_cnt  = r_free_cnt - CW'(1);
                                    n_fresh_cnt = r_fresh_cnt + CW'(1);
                                    n_run_end   = w_q_end;
                                end else begin
                                    // close the run, open one at this block
                                    if (r_have_key) begin
                                        w_z_we = 1'b1;
                                        w_z_wi = r_run_s;
                                        w_z_wd = w_run_len[SW-1:0];
                                    end
                                    n_run_s     = w_bidx;
                                    n_run_start = w_res.addr;
                                    n_run_end   = w_q_end;
                                    n_have_key  = 1'b1;
                                end
                                n_key_a = w_res.addr;
                                n_key_i = w_bidx;
                                n_cnt   = '0;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            S_SPLIT: begin
                // size of the split-off block, then merge
                w_z_we     = 1'b1;
                w_z_wi     = w_fidx;
                w_z_wd     = w_excess;
                n_mode     = MODE_MERGE;
                n_have_key = 1'b0;
                n_cnt      = '0;
                n_state    = S_SCAN;
            end

            S_DONE: begin
                if (!r_out_vld || i_m_tready) begin
                    n_out_vld  = 1'b1;
                    n_out_data = {1'b0, CNTW'(r_fresh_cnt), CNTW'(r_used_cnt),
                                  CNTW'(r_free_cnt), r_status, r_grant};
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_pv        <= 1'b0;
            r_free_v    <= '0;
            r_used_v    <= '0;
            r_free_cnt  <= '0;
            r_used_cnt  <= '0;
            r_fresh_cnt <= CW'(MAX_BLOCKS);
            r_top       <= '0;
            r_have_key  <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_pv        <= n_pv;
            r_free_v    <= n_free_v;
            r_used_v    <= n_used_v;
            r_free_cnt  <= n_free_cnt;
            r_used_cnt  <= n_used_cnt;
            r_fresh_cnt <= n_fresh_cnt;
            r_top       <= n_top;
            r_have_key  <= n_have_key;
            r_out_vld   <= n_out_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_mode      <= n_mode;
        r_pidx      <= n_pidx;
        r_num       <= n_num;
        r_rel       <= n_rel;
        r_grant     <= n_grant;
        r_status    <= n_status;
        r_key_a     <= n_key_a;
        r_key_i     <= n_key_i;
        r_run_s     <= n_run_s;
        r_run_start <= n_run_start;
        r_run_end   <= n_run_end;
        r_out_data  <= n_out_data;
    end

    // descriptor address table
    always_ff @(posedge i_clk) begin
        if (w_a_we) r_addr_mem[w_a_wi] <= w_a_wd;
        r_mem_a <= r_addr_mem[r_cnt[IW-1:0]];
    end

    // descriptor size table
    always_ff @(posedge i_clk) begin
        if (w_z_we) r_size_mem[w_z_wi] <= w_z_wd;
        r_mem_z <= r_size_mem[r_cnt[IW-1:0]];
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_start <= '0;
            r_heap_limit <= '0;
            r_split_thr  <= TW'(16);
            r_align      <= LW'(2);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_HEAP_START: r_heap_start <= i_cfg_data[AW-1:0];
                CFG_HEAP_LIMIT: r_heap_limit <= i_cfg_data[AW-1:0];
                CFG_SPLIT_THR:  r_split_thr  <= i_cfg_data[TW-1:0];
                CFG_ALIGN_LOG2: r_align      <= i_cfg_data[LW-1:0];
                default:        r_align      <= r_align;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == S_IDLE);
    assign o_m_tvalid  = r_out_vld;
    assign o_m_tdata   = r_out_data;

endmodule
